FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PWLC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pwlc assertion failed");
`define PWLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pwlc assertion failed");
`else
`define PWLC_ASSERT(lbl, clk, rst_n, prop)
`define PWLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/pwlc_pkg.sv
// Package: shared types, codes and command/status bundles of the curve block.
`timescale 1ns / 1ps
`default_nettype none
package pwlc_pkg;

  localparam int PWLC_MAX_POINTS = 16;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_EVAL   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_FULL,
    RES_INVALID,
    RES_EVAL
  } res_kind_t;

  typedef enum logic [1:0] {
    RD_SCAN,
    RD_LO,
    RD_HI
  } rd_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_RD_LO,
    S_RD_HI,
    S_LATCH_HI,
    S_PREP,
    S_MUL,
    S_DIV,
    S_FIN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic      load;
    logic      clear;
    logic      write;
    logic      scan_clr;
    logic      scan_cmp;
    logic      latch_lo;
    logic      latch_hi;
    logic      prep;
    logic      mul;
    logic      div_step;
    logic      finish;
    logic      out_load;
    rd_sel_t   rd_sel;
    res_kind_t res_kind;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       curve_ok;
    logic       scan_last;
    logic       div_last;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/pwlc_ifs.sv
// Interfaces: input and result channels with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface pwlc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  modport source (output valid, operation, point_x, point_y, input ready);
  modport sink (input valid, operation, point_x, point_y, output ready);
endinterface

interface pwlc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] curve_value;
  logic [1:0]         status;
  logic               saturated;
  modport source (output valid, curve_value, status, saturated, input ready);
  modport sink (input valid, curve_value, status, saturated, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/pwlc_ctrl.sv
// Controller: sequences clear, append and evaluate over the datapath.
`timescale 1ns / 1ps
`default_nettype none
module pwlc_ctrl
  import pwlc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t    state_r, state_nxt;
  res_kind_t res_kind_r, res_kind_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      res_kind_r <= RES_ZERO;
    end else begin
      state_r    <= state_nxt;
      res_kind_r <= res_kind_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (sts.op == OP_EVAL && sts.curve_ok) state_nxt = S_SCAN_RD;
        else state_nxt = S_OUT;
      end
      S_SCAN_RD:  state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: state_nxt = sts.scan_last ? S_RD_LO : S_SCAN_RD;
      S_RD_LO:    state_nxt = S_RD_HI;
      S_RD_HI:    state_nxt = S_LATCH_HI;
      S_LATCH_HI: state_nxt = S_PREP;
      S_PREP:     state_nxt = S_MUL;
      S_MUL:      state_nxt = S_DIV;
      S_DIV: begin
        if (sts.div_last) state_nxt = S_FIN;
      end
      S_FIN:      state_nxt = S_OUT;
      S_OUT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.rd_sel   = RD_SCAN;
    cmd.res_kind = res_kind_r;
    res_kind_nxt = res_kind_r;
    in_ready     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DECODE: begin
        case (sts.op)
          OP_CLEAR: begin
            cmd.clear    = 1'b1;
            res_kind_nxt = RES_ZERO;
          end
          OP_APPEND: begin
            cmd.write    = !sts.full;
            res_kind_nxt = sts.full ? RES_FULL : RES_ZERO;
          end
          OP_EVAL: begin
            cmd.scan_clr = sts.curve_ok;
            res_kind_nxt = sts.curve_ok ? RES_EVAL : RES_INVALID;
          end
          default: res_kind_nxt = RES_ZERO;
        endcase
      end
      S_SCAN_RD:  cmd.rd_sel = RD_SCAN;
      S_SCAN_CMP: cmd.scan_cmp = 1'b1;
      S_RD_LO:    cmd.rd_sel = RD_LO;
      S_RD_HI: begin
        cmd.rd_sel   = RD_HI;
        cmd.latch_lo = 1'b1;
      end
      S_LATCH_HI: cmd.latch_hi = 1'b1;
      S_PREP:     cmd.prep = 1'b1;
      S_MUL:      cmd.mul = 1'b1;
      S_DIV:      cmd.div_step = 1'b1;
      S_FIN:      cmd.finish = 1'b1;
      S_OUT:      cmd.out_load = sts.out_free;
      default:    cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/pwlc_datapath.sv
// Datapath: breakpoint memory, segment search, multiply, serial divide, output register.
`timescale 1ns / 1ps
`default_nettype none
module pwlc_datapath
  import pwlc_pkg::*;
#(
  parameter int MAX_POINTS = PWLC_MAX_POINTS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cmd_t               cmd,
  output sts_t                    sts,
  input  wire logic [1:0]         in_operation,
  input  wire logic signed [31:0] in_point_x,
  input  wire logic signed [31:0] in_point_y,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic signed [31:0]      out_curve_value,
  output logic [1:0]              out_status,
  output logic                    out_saturated
);

  localparam int AW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  logic signed [31:0] mem_x [MAX_POINTS];
  logic signed [31:0] mem_y [MAX_POINTS];

  logic [1:0]         op_r;
  logic signed [31:0] qx_r, qy_r;
  logic [CW-1:0]      count_r;
  logic               order_ok_r;
  logic signed [31:0] last_x_r;
  logic signed [31:0] rd_x_r, rd_y_r;
  logic [AW-1:0]      k_r, lo_r;
  logic               below_r;
  logic signed [31:0] xa_r, ya_r, xb_r, yb_r;
  logic [31:0]        mag_dy_r, mag_t_r, dx_r;
  logic               neg_r;
  logic signed [31:0] yanc_r;
  logic [63:0]        dvd_r;
  logic [31:0]        rem_r;
  logic [5:0]         cnt_r;
  logic signed [31:0] val_r;
  logic               sat_r;
  logic               out_valid_r;
  logic signed [31:0] out_value_r;
  logic [1:0]         out_status_r;
  logic               out_sat_r;

  logic [AW-1:0]      raddr;
  logic signed [32:0] dy_w, t_w;
  logic [32:0]        dx_w;
  logic [32:0]        sh_w;
  logic [33:0]        diff_w;
  logic               ge_w;
  logic               capped_w, rnd_w;
  logic [40:0]        q_w;
  logic signed [42:0] sum_w;

  always_comb begin
    case (cmd.rd_sel)
      RD_SCAN: raddr = k_r;
      RD_LO:   raddr = lo_r;
      RD_HI:   raddr = lo_r + AW'(1);
      default: raddr = k_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem_x[count_r[AW-1:0]] <= qx_r;
      mem_y[count_r[AW-1:0]] <= qy_r;
    end
    rd_x_r <= mem_x[raddr];
    rd_y_r <= mem_y[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      order_ok_r <= 1'b1;
    end else if (cmd.clear) begin
      count_r    <= '0;
      order_ok_r <= 1'b1;
    end else if (cmd.write) begin
      count_r <= count_r + CW'(1);
      if (count_r != '0 && qx_r <= last_x_r) order_ok_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_operation;
      qx_r <= in_point_x;
      qy_r <= in_point_y;
    end
    if (cmd.write) last_x_r <= qx_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      k_r     <= '0;
      lo_r    <= '0;
      below_r <= 1'b0;
    end else if (cmd.scan_cmp) begin
      if (k_r == '0) below_r <= (qx_r < rd_x_r);
      else if (qx_r >= rd_x_r) lo_r <= k_r;
      k_r <= k_r + AW'(1);
    end
  end

  assign dy_w = 33'(yb_r) - 33'(ya_r);
  assign dx_w = 33'(xb_r) - 33'(xa_r);
  assign t_w  = 33'(qx_r) - (below_r ? 33'(xa_r) : 33'(xb_r));

  always_ff @(posedge clk) begin
    if (cmd.latch_lo) begin
      xa_r <= rd_x_r;
      ya_r <= rd_y_r;
    end
    if (cmd.latch_hi) begin
      xb_r <= rd_x_r;
      yb_r <= rd_y_r;
    end
    if (cmd.prep) begin
      mag_dy_r <= dy_w[32] ? 32'(-dy_w) : dy_w[31:0];
      mag_t_r  <= t_w[32] ? 32'(-t_w) : t_w[31:0];
      dx_r     <= dx_w[31:0];
      neg_r    <= dy_w[32] ^ t_w[32];
      yanc_r   <= below_r ? ya_r : yb_r;
    end
  end

  assign sh_w   = {rem_r, dvd_r[63]};
  assign diff_w = {1'b0, sh_w} - {2'b00, dx_r};
  assign ge_w   = !diff_w[33];

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      dvd_r <= mag_dy_r * mag_t_r;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[62:0], ge_w};
      rem_r <= ge_w ? diff_w[31:0] : sh_w[31:0];
      cnt_r <= cnt_r + 6'd1;
    end
  end

  assign capped_w = |dvd_r[63:40];
  assign rnd_w    = ({rem_r, 1'b0} >= {1'b0, dx_r});
  assign q_w      = capped_w ? (41'd1 << 40) : (dvd_r[40:0] + 41'(rnd_w));
  assign sum_w    = neg_r ? (43'(yanc_r) - 43'(q_w)) : (43'(yanc_r) + 43'(q_w));

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (sum_w > 43'sd2147483647) begin
        val_r <= 32'sh7fffffff;
        sat_r <= 1'b1;
      end else if (sum_w < -43'sd2147483648) begin
        val_r <= 32'sh80000000;
        sat_r <= 1'b1;
      end else begin
        val_r <= sum_w[31:0];
        sat_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value_r <= (cmd.res_kind == RES_EVAL) ? val_r : '0;
      out_sat_r   <= (cmd.res_kind == RES_EVAL) && sat_r;
      case (cmd.res_kind)
        RES_FULL:    out_status_r <= ST_FULL;
        RES_INVALID: out_status_r <= ST_INVALID;
        default:     out_status_r <= ST_OK;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_curve_value = out_value_r;
  assign out_status      = out_status_r;
  assign out_saturated   = out_sat_r;

  assign sts.op        = op_r;
  assign sts.full      = (count_r == CW'(MAX_POINTS));
  assign sts.curve_ok  = (count_r >= CW'(2)) && order_ok_r;
  assign sts.scan_last = ({{(CW - AW){1'b0}}, k_r} == count_r - CW'(2));
  assign sts.div_last  = &cnt_r;
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule
`default_nettype wire

FILE: rtl/core/piecewise_linear_curve_top.sv
// Piecewise linear curve evaluator with breakpoint table, top level.
// Clear, append and an evaluate of an invalid curve go from acceptance
// through decode to the output register. A valid evaluate first runs the
// segment search, which reads the breakpoint memory one entry at a time,
// then a multiply; the 64-bit by 32-bit restoring divider resolves one
// quotient bit per cycle. One item is in flight at a time; a finished
// result waits in the output register while the next item is accepted.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module piecewise_linear_curve_top
  import pwlc_pkg::*;
#(
  parameter int MAX_POINTS = PWLC_MAX_POINTS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pwlc_in_if.sink   in_ch,
  pwlc_out_if.source out_ch
);

  cmd_t cmd;
  sts_t sts;

  pwlc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pwlc_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_operation    (in_ch.operation),
    .in_point_x      (in_ch.point_x),
    .in_point_y      (in_ch.point_y),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_curve_value (out_ch.curve_value),
    .out_status      (out_ch.status),
    .out_saturated   (out_ch.saturated)
  );

  `PWLC_ASSERT_NEXT(a_busy_after_beat, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
  `PWLC_ASSERT(a_load_when_free, clk, rst_n, !cmd.out_load || sts.out_free)
  `PWLC_ASSERT(a_no_write_when_full, clk, rst_n, !cmd.write || !sts.full)

endmodule
`default_nettype wire

FILE: dv/piecewise_linear_curve_top_tb.sv
// Testbench: random and directed breakpoint tables and queries, scored against a curve predictor.
`timescale 1ns / 1ps
module piecewise_linear_curve_top_tb;
  import pwlc_pkg::*;

  localparam int IDLE_PCT   = 37;
  localparam int STALL_MAX  = 20000;
  localparam int DRAIN_CYC  = 300;
  localparam int N_ITEMS    = 700;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [31:0] curve_value;
    logic [1:0]         status;
    logic               saturated;
  } curve_result_t;

  class curve_scoreboard;
    logic signed [31:0] knot_x[PWLC_MAX_POINTS];
    logic signed [31:0] knot_y[PWLC_MAX_POINTS];
    int                 n_knots;
    bit                 ascending;
    curve_result_t      pending_results[$];
    int                 errors;

    function new();
      n_knots   = 0;
      ascending = 1;
      errors    = 0;
    endfunction

    function longint segment_y(int lo, int anc, longint qx);
      longint       dy, dx, t, qv;
      bit           neg;
      logic [127:0] ady, at, prod, quo, rem, dxw;
      dy   = longint'(knot_y[lo+1]) - longint'(knot_y[lo]);
      dx   = longint'(knot_x[lo+1]) - longint'(knot_x[lo]);
      t    = qx - longint'(knot_x[anc]);
      neg  = (dy < 0) != (t < 0);
      ady  = (dy < 0) ? -dy : dy;
      at   = (t < 0) ? -t : t;
      dxw  = dx;
      prod = ady * at;
      quo  = prod / dxw;
      rem  = prod % dxw;
      if (quo >= (128'd1 << 40)) begin
        qv = longint'(1) << 40;
      end else begin
        qv = longint'(quo[63:0]);
        if (rem >= dxw - rem) qv++;
      end
      if (ady == 0 || at == 0) qv = 0;
      return longint'(knot_y[anc]) + (neg ? -qv : qv);
    endfunction

    function void note_item(logic [1:0] op, logic signed [31:0] px, logic signed [31:0] py);
      curve_result_t r;
      longint        v, qx;
      int            i;
      r  = '0;
      qx = px;
      case (op)
        OP_CLEAR: begin
          n_knots   = 0;
          ascending = 1;
        end
        OP_APPEND: begin
          if (n_knots >= PWLC_MAX_POINTS) begin
            r.status = ST_FULL;
          end else begin
            if (n_knots > 0 && px <= knot_x[n_knots-1]) ascending = 0;
            knot_x[n_knots] = px;
            knot_y[n_knots] = py;
            n_knots++;
          end
        end
        OP_EVAL: begin
          if (n_knots < 2 || !ascending) begin
            r.status = ST_INVALID;
          end else begin
            if (qx < knot_x[0]) begin
              v = segment_y(0, 0, qx);
            end else if (qx >= knot_x[n_knots-1]) begin
              v = segment_y(n_knots - 2, n_knots - 1, qx);
            end else begin
              i = 0;
              while (i + 2 < n_knots && qx >= knot_x[i+1]) i++;
              v = segment_y(i, i + 1, qx);
            end
            if (v > 64'sd2147483647) begin
              v = 64'sd2147483647;
              r.saturated = 1;
            end else if (v < -64'sd2147483648) begin
              v = -64'sd2147483648;
              r.saturated = 1;
            end
            r.curve_value = v[31:0];
          end
        end
        default: ;
      endcase
      pending_results = {pending_results, r};
    endfunction

    function void check_result(curve_result_t got);
      curve_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value=%0d status=%0d sat=%0d", $time,
                 got.curve_value, got.status, got.saturated);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.curve_value !== want.curve_value) begin
        $display("%0t: curve_value expected %0d actual %0d", $time, want.curve_value,
                 got.curve_value);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.saturated !== want.saturated) begin
        $display("%0t: saturated expected %0d actual %0d", $time, want.saturated,
                 got.saturated);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   calm;
  int   quiet_cycles;
  int   items_sent;
  curve_scoreboard sb;

  pwlc_in_if  in_ch();
  pwlc_out_if out_ch();

  piecewise_linear_curve_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  task automatic send_item(logic [1:0] op, logic signed [31:0] px, logic signed [31:0] py);
    bit fire;
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_ch.valid     <= 1;
    in_ch.operation <= op;
    in_ch.point_x   <= px;
    in_ch.point_y   <= py;
    do begin
      @(negedge clk);
      fire = in_ch.ready;
      @(posedge clk);
    end while (!fire);
    sb.note_item(op, px, py);
    items_sent++;
  endtask

  function automatic logic signed [31:0] rand_q();
    return $signed($urandom) >>> $urandom_range(0, 31);
  endfunction

  task automatic random_curve();
    logic signed [31:0] xs[$];
    int n, sh, k, evals;
    n  = ($urandom_range(9) == 0) ? $urandom_range(15, 18) : $urandom_range(2, 8);
    sh = $urandom_range(0, 28);
    for (k = 0; k < n; k++) xs = {xs, $signed($urandom) >>> sh};
    if ($urandom_range(9) != 0) xs.sort();
    send_item(OP_CLEAR, rand_q(), rand_q());
    foreach (xs[j]) send_item(OP_APPEND, xs[j], rand_q());
    evals = $urandom_range(1, 6);
    for (k = 0; k < evals; k++) begin
      if ($urandom_range(3) == 0) send_item(OP_EVAL, $urandom, rand_q());
      else send_item(OP_EVAL, xs[$urandom_range(n - 1)] + ($signed($urandom) >>> (sh + 2)),
                     rand_q());
    end
  endtask

  initial begin
    int k;
    sb              = new();
    rst_n           <= 0;
    in_ch.valid     <= 0;
    in_ch.operation <= OP_CLEAR;
    in_ch.point_x   <= '0;
    in_ch.point_y   <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send_item(OP_EVAL, 32'sd0, 32'sd0);
    send_item(OP_APPEND, 32'sh8000_0000, 32'sh7fff_ffff);
    send_item(OP_EVAL, 32'sd5, 32'sd0);
    send_item(OP_APPEND, 32'sh7fff_ffff, 32'sh8000_0000);
    send_item(OP_EVAL, 32'sh8000_0000, 32'sh7fff_ffff);
    send_item(OP_EVAL, 32'sh7fff_ffff, 32'sd0);
    send_item(OP_EVAL, 32'sd0, 32'sd0);
    send_item(OP_CLEAR, 32'sd0, 32'sd0);
    send_item(OP_APPEND, 32'sd0, 32'sd0);
    send_item(OP_APPEND, 32'sd1, 32'sh7fff_ffff);
    send_item(OP_EVAL, 32'sd3, 32'sd0);
    send_item(OP_EVAL, -32'sd3, 32'sd0);
    send_item(OP_EVAL, 32'sd1, 32'sd0);
    send_item(OP_APPEND, 32'sd1, 32'sd7);
    send_item(OP_EVAL, 32'sd0, 32'sd0);
    send_item(OP_UNUSED, 32'shffff_ffff, 32'shffff_ffff);
    send_item(OP_CLEAR, 32'sd0, 32'sd0);
    for (k = 0; k < PWLC_MAX_POINTS + 1; k++)
      send_item(OP_APPEND, k * 32'sh0001_0000, k * 32'sh0000_8001);
    send_item(OP_EVAL, 32'sh0008_8000, 32'sd0);
    send_item(OP_EVAL, 32'sh0002_0000, 32'sd0);
    send_item(OP_EVAL, 32'sh0002_0001, 32'sd0);

    while (items_sent < N_ITEMS) begin
      calm = (items_sent > 250 && items_sent < 400);
      if ($urandom_range(9) == 0) send_item($urandom_range(3), $urandom, $urandom);
      else random_curve();
    end
    calm = 0;
    in_ch.valid <= 0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (sb.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    out_ch.ready <= 0;
    forever begin
      @(posedge clk);
      out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    curve_result_t got;
    quiet_cycles = 0;
    forever begin
      @(negedge clk);
      if (out_ch.valid && out_ch.ready && rst_n) begin
        got.curve_value = out_ch.curve_value;
        got.status      = out_ch.status;
        got.saturated   = out_ch.saturated;
        sb.check_result(got);
      end
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_MAX) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end
endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/pwlc_pkg.sv
rtl/core/pwlc_ifs.sv
rtl/core/pwlc_ctrl.sv
rtl/core/pwlc_datapath.sv
rtl/core/piecewise_linear_curve_top.sv
dv/piecewise_linear_curve_top_tb.sv
